FILE: design/bcs_pkg.sv
// Shared types and constants for the BCD time-of-day clock with serial set.
// No dependencies; used by every module of the block.
package bcs_pkg;

  localparam int unsigned CellCount = 8;
  localparam int unsigned CellIdxW  = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned PairW      = 12;

  localparam logic [7:0] CHAR_BIAS    = 8'd48;
  localparam logic [7:0] SET_MARK     = 8'h25;
  localparam logic [7:0] REPORT_OPEN  = 8'h5B;
  localparam logic [7:0] REPORT_CLOSE = 8'h0A;

  localparam logic [PairW-1:0] SEC_WRAP  = 12'd60;
  localparam logic [PairW-1:0] MIN_WRAP  = 12'd60;
  localparam logic [PairW-1:0] HOUR_WRAP = 12'd24;

  // floor(v * 3277 / 2^15) equals floor(v / 10) for every v below 16384.
  localparam logic [PairW-1:0] DIV10_MAGIC = 12'd3277;
  localparam int unsigned      DIV10_SHIFT = 15;

  localparam logic [7:0] CELL_RESET [CellCount] = '{
    8'd1, 8'd3, 8'd10, 8'd4, 8'd5, 8'd10, 8'd3, 8'd5
  };

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_TICK  = 1'b1
  } cmd_kind_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } opcode_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CellIdxW-1:0] pos;
    logic [7:0]          data;
  } cmd_t;

endpackage

FILE: design/bcs_front.sv
// Front end: accepts input words, tracks set mode and turns them into commands.
// Depends on bcs_pkg; feeds bcs_queue.
module bcs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                q_push,
  output bcs_pkg::cmd_t       q_cmd
);

  logic                             setting_r, setting_nxt;
  logic [bcs_pkg::CellIdxW-1:0]     set_pos_r, set_pos_nxt;
  logic                             accept;
  logic                             is_byte;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_byte  = (in_opcode == bcs_pkg::OP_BYTE);

  always_comb begin
    setting_nxt = setting_r;
    set_pos_nxt = set_pos_r;
    q_push      = 1'b0;
    q_cmd.kind  = bcs_pkg::KIND_TICK;
    q_cmd.pos   = set_pos_r;
    q_cmd.data  = in_rx_byte - bcs_pkg::CHAR_BIAS;
    if (accept) begin
      if (is_byte) begin
        if (in_rx_byte == bcs_pkg::SET_MARK) begin
          setting_nxt = 1'b1;
          set_pos_nxt = '0;
        end else if (setting_r) begin
          q_push      = 1'b1;
          q_cmd.kind  = bcs_pkg::KIND_STORE;
          set_pos_nxt = set_pos_r + 1'b1;
          // The eighth stored word ends set mode; the position wraps to zero.
          if (set_pos_r == bcs_pkg::CellIdxW'(bcs_pkg::CellCount - 1)) begin
            setting_nxt = 1'b0;
          end
        end
      end else if (!setting_r) begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setting_r <= 1'b0;
      set_pos_r <= '0;
    end else begin
      setting_r <= setting_nxt;
      set_pos_r <= set_pos_nxt;
    end
  end

endmodule

FILE: design/bcs_queue.sv
// Short command queue between the front end and the time-keeping back end.
// Depends on bcs_pkg for the command type and depth.
module bcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bcs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output bcs_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);

  bcs_pkg::cmd_t                   slots_r [bcs_pkg::QueueDepth];
  logic [bcs_pkg::QueuePtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [bcs_pkg::QueuePtrW:0]     count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (bcs_pkg::QueuePtrW + 1)'(bcs_pkg::QueueDepth));
  assign head_cmd = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/bcs_back.sv
// Back end: holds the time cells, applies stored digits, advances the clock
// and streams the ten-word report through an output register. Uses bcs_pkg.
module bcs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  bcs_pkg::cmd_t head_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_tx_byte,
  output logic          out_last_of_report
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SEND = 3'b100
  } back_state_t;

  localparam int unsigned PW = bcs_pkg::PairW;
  localparam logic [3:0] LAST_IDX = 4'd9;

  back_state_t         state_r, state_nxt;
  logic [7:0]          cells_r [bcs_pkg::CellCount];
  logic [PW-1:0]       hr_r, mn_r, sc_r;
  logic [PW-1:0]       hr_nxt, mn_nxt, sc_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_en;
  logic                do_store, do_tick;
  logic [bcs_pkg::CellIdxW-1:0] send_cell;
  logic [8:0]          hr_q, mn_q, sc_q;

  function automatic logic [PW-1:0] pair_val(input logic [7:0] tens, input logic [7:0] ones);
    logic [PW-1:0] t;
    t = PW'(tens);
    return (t << 3) + (t << 1) + PW'(ones);
  endfunction

  function automatic logic [8:0] div10(input logic [PW-1:0] v);
    logic [2*PW-1:0] p;
    p = (2*PW)'(v) * (2*PW)'(bcs_pkg::DIV10_MAGIC);
    return p[bcs_pkg::DIV10_SHIFT +: 9];
  endfunction

  function automatic logic [7:0] rem10(input logic [PW-1:0] v, input logic [8:0] q);
    logic [PW-1:0] q10;
    q10 = (PW'(q) << 3) + (PW'(q) << 1);
    return 8'((v - q10) & PW'(4'hF));
  endfunction

  assign out_en    = !out_valid_r || out_ready;
  assign do_store  = (state_r == ST_IDLE) && !q_empty && (head_cmd.kind == bcs_pkg::KIND_STORE);
  assign do_tick   = (state_r == ST_IDLE) && !q_empty && (head_cmd.kind == bcs_pkg::KIND_TICK)
                     && out_en;
  assign q_pop     = do_store || do_tick;
  assign send_cell = 3'(idx_r - 4'd1);

  assign hr_q = div10(hr_r);
  assign mn_q = div10(mn_r);
  assign sc_q = div10(sc_r);

  // New pair values; a carry happens only on an exact wrap count.
  always_comb begin
    hr_nxt = pair_val(cells_r[0], cells_r[1]);
    mn_nxt = pair_val(cells_r[3], cells_r[4]);
    sc_nxt = pair_val(cells_r[6], cells_r[7]) + 1'b1;
    if (sc_nxt == bcs_pkg::SEC_WRAP) begin
      sc_nxt = '0;
      mn_nxt = mn_nxt + 1'b1;
      if (mn_nxt == bcs_pkg::MIN_WRAP) begin
        mn_nxt = '0;
        hr_nxt = hr_nxt + 1'b1;
        if (hr_nxt == bcs_pkg::HOUR_WRAP) begin
          hr_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_tick) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = bcs_pkg::REPORT_OPEN;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        idx_nxt   = 4'd1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_en) begin
          out_valid_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            out_byte_nxt = bcs_pkg::REPORT_CLOSE;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            out_byte_nxt = cells_r[send_cell] + bcs_pkg::CHAR_BIAS;
            out_last_nxt = 1'b0;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bcs_pkg::CellCount; i++) begin
        cells_r[i] <= bcs_pkg::CELL_RESET[i];
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_store) begin
        cells_r[head_cmd.pos] <= head_cmd.data;
      end
      if (state_r == ST_DIV) begin
        cells_r[0] <= hr_q[7:0];
        cells_r[1] <= rem10(hr_r, hr_q);
        cells_r[3] <= mn_q[7:0];
        cells_r[4] <= rem10(mn_r, mn_q);
        cells_r[6] <= sc_q[7:0];
        cells_r[7] <= rem10(sc_r, sc_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (do_tick) begin
      hr_r <= hr_nxt;
      mn_r <= mn_nxt;
      sc_r <= sc_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_byte        = out_byte_r;
  assign out_last_of_report = out_last_r;

endmodule

FILE: design/bcd_clock_with_serial_set_core.sv
// With the back end idle, popping a tick updates the pairs and loads the '[' word into the
// output register; the divide-by-ten step, eight cell words and the newline follow.
// Throughput: one input word per cycle while the two-entry command queue is not full; a stored
// digit is written into its cell when popped, a tick runs the pair update, divide-by-ten and
// nine words, and the back end takes no new command until it is idle again.
// Reset (synchronous, rst_n low) loads 13:45:35, clears set mode and empties the queue.
module bcd_clock_with_serial_set_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_report
);

  logic          q_push, q_pop, q_full, q_empty;
  bcs_pkg::cmd_t q_cmd, head_cmd;

  bcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_rx_byte(in_rx_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  bcs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .empty   (q_empty),
    .full    (q_full)
  );

  bcs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head_cmd          (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_last_of_report(out_last_of_report)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full || q_pop))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command queue read while empty");

  a_last_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_report) |-> (out_tx_byte == bcs_pkg::REPORT_CLOSE))
    else $error("report end flag on a word other than newline");

endmodule
